>>> rtl/assert_macros.svh
// Assertion macros used by the top level of the reachability block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of clk outside reset.
`define GRDFS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grdfs assertion failed");

// Property that must hold on every rising edge of clk outside reset.
`define GRDFS_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("grdfs assertion failed");

`endif

>>> rtl/grdfs_pkg.sv
// Package with the constants, codes and types of the reachability block.
`default_nettype none

package grdfs_pkg;

    localparam int NODES  = 64;
    localparam int NODE_W = $clog2(NODES);
    localparam int CNT_W  = $clog2(NODES + 1);

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [NODES-1:0]  row_t;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    // Result of the lowest-set-bit search.
    typedef struct packed {
        logic  found;
        node_t index;
    } ffs_res_t;

endpackage

`default_nettype wire

>>> rtl/grdfs_if.sv
// Request and response channel interfaces of the reachability block.
`default_nettype none

interface grdfs_req_if import grdfs_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    node_t       node_a;
    node_t       node_b;

    modport source (output valid, command, node_a, node_b, input ready);
    modport sink   (input valid, command, node_a, node_b, output ready);
endinterface

interface grdfs_rsp_if import grdfs_pkg::*; ();
    logic valid;
    logic ready;
    logic reachable;

    modport source (output valid, reachable, input ready);
    modport sink   (input valid, reachable, output ready);
endinterface

`default_nettype wire

>>> rtl/grdfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module grdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/grdfs_ffs.sv
// Lowest-set-bit search over one adjacency row.
`default_nettype none

module grdfs_ffs import grdfs_pkg::*; (
    input  wire row_t     vec,
    output      ffs_res_t res
);

    always_comb
    begin
        res.found = |vec;
        res.index = '0;
        for (int i = NODES - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                res.index = NODE_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/graph_reachability_dfs_top.sv
// Top level of the graph reachability block: sequencer, graph store and search stack.
`default_nettype none

// The block holds an undirected graph of 64 nodes as a 64 x 64 adjacency bit
// matrix in a RAM, with one valid flip-flop per row so that reset and the clear
// command empty the graph without touching the RAM. Each request carries a
// command: clear (no response), add edge (no response: row a is read, then
// written with bit b set while row b is read, then row b is written with bit
// a set), or query (exactly one response). Command code 3 is dropped. A query
// runs a depth-first search: the node stack lives in a second RAM, the visited
// set in a 64-bit register, and one shared lowest-set-bit unit picks the first
// unvisited neighbour of the node on top of the stack. Both RAMs have a registered
// read port and each step waits for one row read, so a pop passes through a wait
// state for the stack read; the pop that empties the stack ends the search. A
// query where the start equals the goal goes straight to the done state; any other
// one runs up to 63 pushes and 62 pops or up to 62 pushes and 63 pops before it,
// and stops as soon as the goal is pushed. The block takes one request at a time
// and is not ready while a request is in work. The response sits in an output
// register, so the next request is accepted while a response still waits; a
// finished query holds until that register is free.

`include "assert_macros.svh"

module graph_reachability_dfs_top import grdfs_pkg::*; (
    input wire logic  clk,
    input wire logic  rst_n,
    grdfs_req_if.sink   req,
    grdfs_rsp_if.source rsp
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_ADD_WRA  = 6'b000010,
        ST_ADD_WRB  = 6'b000100,
        ST_STEP     = 6'b001000,
        ST_POP_WAIT = 6'b010000,
        ST_DONE     = 6'b100000
    } state_t;

    state_t   state_reg, state_next;
    row_t     row_valid_reg, row_valid_next;
    logic     rd_valid_reg;
    row_t     visited_reg, visited_next;
    cnt_t     count_reg, count_next;
    node_t    node_a_reg, node_a_next;
    node_t    node_b_reg, node_b_next;
    logic     result_reg, result_next;
    logic     out_valid_reg, out_valid_next;
    logic     out_data_reg, out_data_next;

    // Adjacency RAM ports.
    logic     adj_we;
    node_t    adj_waddr;
    row_t     adj_wdata;
    logic     adj_re;
    node_t    adj_raddr;
    row_t     adj_rdata;
    row_t     adj_row;

    // Stack RAM ports.
    logic     stk_we;
    node_t    stk_waddr;
    node_t    stk_wdata;
    logic     stk_re;
    node_t    stk_raddr;
    node_t    stk_rdata;

    ffs_res_t ffs_res;
    logic     accept;
    cnt_t     count_less2;

    grdfs_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .re    (adj_re),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    grdfs_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // A row that was never written since the last clear reads as empty.
    assign adj_row = rd_valid_reg ? adj_rdata : '0;

    // The shared search unit looks for the first unvisited neighbour.
    grdfs_ffs u_ffs (
        .vec (adj_row & ~visited_reg),
        .res (ffs_res)
    );

    assign req.ready     = (state_reg == ST_IDLE);
    assign accept        = req.valid && req.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.reachable = out_data_reg;
    assign count_less2   = count_reg - CNT_W'(2);

    always_comb
    begin
        state_next     = state_reg;
        row_valid_next = row_valid_reg;
        visited_next   = visited_reg;
        count_next     = count_reg;
        node_a_next    = node_a_reg;
        node_b_next    = node_b_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;

        adj_we    = 1'b0;
        adj_waddr = node_a_reg;
        adj_wdata = adj_row;
        adj_re    = 1'b0;
        adj_raddr = node_a_reg;
        stk_we    = 1'b0;
        stk_waddr = count_reg[NODE_W-1:0];
        stk_wdata = ffs_res.index;
        stk_re    = 1'b0;
        stk_raddr = count_less2[NODE_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    node_a_next = req.node_a;
                    node_b_next = req.node_b;
                    if (req.command == CMD_CLEAR)
                    begin
                        row_valid_next = '0;
                    end
                    else if (req.command == CMD_ADD)
                    begin
                        adj_re     = 1'b1;
                        adj_raddr  = req.node_a;
                        state_next = ST_ADD_WRA;
                    end
                    else if (req.command == CMD_QUERY)
                    begin
                        if (req.node_a == req.node_b)
                        begin
                            result_next = 1'b1;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            visited_next = row_t'(1) << req.node_a;
                            count_next   = CNT_W'(1);
                            stk_we       = 1'b1;
                            stk_waddr    = '0;
                            stk_wdata    = req.node_a;
                            adj_re       = 1'b1;
                            adj_raddr    = req.node_a;
                            state_next   = ST_STEP;
                        end
                    end
                end
            end

            ST_ADD_WRA:
            begin
                adj_we                     = 1'b1;
                adj_waddr                  = node_a_reg;
                adj_wdata                  = adj_row | (row_t'(1) << node_b_reg);
                row_valid_next[node_a_reg] = 1'b1;
                adj_re                     = 1'b1;
                adj_raddr                  = node_b_reg;
                state_next                 = ST_ADD_WRB;
            end

            ST_ADD_WRB:
            begin
                adj_we                     = 1'b1;
                adj_waddr                  = node_b_reg;
                adj_wdata                  = adj_row | (row_t'(1) << node_a_reg);
                row_valid_next[node_b_reg] = 1'b1;
                state_next                 = ST_IDLE;
            end

            ST_STEP:
            begin
                if (ffs_res.found)
                begin
                    // Push the neighbour; the goal is tested as it is pushed.
                    visited_next[ffs_res.index] = 1'b1;
                    stk_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (ffs_res.index == node_b_reg)
                    begin
                        result_next = 1'b1;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        adj_re    = 1'b1;
                        adj_raddr = ffs_res.index;
                    end
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        result_next = 1'b0;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        stk_re     = 1'b1;
                        state_next = ST_POP_WAIT;
                    end
                end
            end

            ST_POP_WAIT:
            begin
                adj_re     = 1'b1;
                adj_raddr  = stk_rdata;
                state_next = ST_STEP;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            visited_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            if (adj_re)
            begin
                rd_valid_reg <= row_valid_reg[adj_raddr];
            end
            visited_reg   <= visited_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_a_reg   <= node_a_next;
        node_b_reg   <= node_b_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

    // The stack never holds more entries than there are nodes.
    `GRDFS_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(NODES))
    // While searching, the stack is never empty.
    `GRDFS_ASSERT_IMP(a_step_nonempty, state_reg == ST_STEP, count_reg != '0)
    // The search unit never offers a node that was already visited.
    `GRDFS_ASSERT_IMP(a_push_fresh, (state_reg == ST_STEP) && ffs_res.found,
                      !visited_reg[ffs_res.index])
    // A finished query only leaves when the output register can take it.
    `GRDFS_ASSERT_IMP(a_done_output, (state_reg == ST_DONE) && (state_next == ST_IDLE),
                      out_valid_next)

endmodule

`default_nettype wire
